// File: design/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared constants, types and the key ordering function of the binary-heap
// priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int EXT_W    = ADDR_W + 2;
    localparam int KEY_W    = 32;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [KEY_W-1:0] SENTINEL_MIN_MODE = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] SENTINEL_MAX_MODE = 32'sh8000_0000;

    typedef enum logic [2:0] {
        RD_ROOT   = 3'd0,
        RD_LAST   = 3'd1,
        RD_PARENT = 3'd2,
        RD_LC     = 3'd3,
        RD_RC     = 3'd4
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_INS_OK = 2'd0,
        RES_FULL   = 2'd1,
        RES_EMPTY  = 2'd2,
        RES_EXT_OK = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic      init_ins;
        logic      mem_rd;
        rd_sel_t   rd_sel;
        logic      cap_root;
        logic      cap_last;
        logic      cap_lc;
        logic      wr_cur;
        logic      up_move;
        logic      dn_move;
        logic      res_load;
        res_kind_t res_kind;
    } bhpq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic lc_in;
        logic rc_in;
        logic up_beats;
        logic dn_beats;
    } bhpq_stat_t;

    // True when key a must sit above key b. Mode 1 keeps the smallest at the root.
    function automatic logic beats(input logic signed [KEY_W-1:0] a,
                                   input logic signed [KEY_W-1:0] b,
                                   input logic mode);
        beats = mode ? (a < b) : (a > b);
    endfunction

endpackage

// File: design/bhpq_ctrl.sv
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Controller state machine: sequences the sift-up and sift-down walks and
// the result transfer.
// ----------------------------------------------------------------------------
module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       req_type,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  bhpq_stat_t stat,
    output bhpq_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_UP_CHK  = 9'b000000010,
        S_UP_CMP  = 9'b000000100,
        S_EX_LAST = 9'b000001000,
        S_EX_CUR  = 9'b000010000,
        S_DN_CHK  = 9'b000100000,
        S_DN_LC   = 9'b001000000,
        S_DN_SEL  = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;
    logic      rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.rd_sel   = RD_ROOT;
        cmd.res_kind = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (!req_type)
                    begin
                        if (stat.full)
                        begin
                            kind_next  = RES_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.init_ins = 1'b1;
                            kind_next    = RES_INS_OK;
                            state_next   = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            kind_next  = RES_EMPTY;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.mem_rd = 1'b1;
                            cmd.rd_sel = RD_ROOT;
                            kind_next  = RES_EXT_OK;
                            state_next = S_EX_LAST;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_beats)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_EX_LAST:
            begin
                cmd.cap_root = 1'b1;
                cmd.mem_rd   = 1'b1;
                cmd.rd_sel   = RD_LAST;
                state_next   = S_EX_CUR;
            end
            S_EX_CUR:
            begin
                cmd.cap_last = 1'b1;
                state_next   = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (!stat.lc_in)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_LC;
                    state_next = S_DN_LC;
                end
            end
            S_DN_LC:
            begin
                cmd.cap_lc = 1'b1;
                cmd.mem_rd = stat.rc_in;
                cmd.rd_sel = RD_RC;
                state_next = S_DN_SEL;
            end
            S_DN_SEL:
            begin
                if (stat.dn_beats)
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_CHK;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // The result waits here until the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= RES_INS_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: design/bhpq_dpath.sv
// ----------------------------------------------------------------------------
// bhpq_dpath
// Datapath: heap store, moving key and position, key comparisons, entry
// count and the result register.
// ----------------------------------------------------------------------------
module bhpq_dpath
    import bhpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    mode,
    input  logic signed [KEY_W-1:0] key_value,
    input  bhpq_cmd_t               cmd,
    output bhpq_stat_t              stat,
    output logic signed [KEY_W-1:0] root_value,
    output logic [1:0]              status,
    output logic [7:0]              entry_count
);

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic signed [KEY_W-1:0] rd_data_reg;
    logic signed [KEY_W-1:0] cur_reg, cur_next;
    logic signed [KEY_W-1:0] best_reg, best_next;
    logic signed [KEY_W-1:0] root_reg, root_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic [ADDR_W-1:0]       best_idx_reg, best_idx_next;
    logic                    has_rc_reg, has_rc_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [KEY_W-1:0] out_root_reg;
    logic [1:0]              out_status_reg;
    logic [7:0]              out_count_reg;

    logic [EXT_W-1:0]        lc_ext, rc_ext, count_ext;
    logic [ADDR_W-1:0]       parent_idx, last_idx, rd_addr;
    logic signed [KEY_W-1:0] sel_key, wr_data;
    logic [ADDR_W-1:0]       sel_idx;
    logic                    wr_en;

    assign lc_ext     = {1'b0, pos_reg, 1'b1};
    assign rc_ext     = lc_ext + EXT_W'(1);
    assign count_ext  = EXT_W'(count_reg);
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign last_idx   = ADDR_W'(count_reg - CNT_W'(1));

    // The right child replaces the left one only when it strictly beats it.
    always_comb
    begin
        if (has_rc_reg && beats(rd_data_reg, best_reg, mode))
        begin
            sel_key = rd_data_reg;
            sel_idx = ADDR_W'(rc_ext);
        end
        else
        begin
            sel_key = best_reg;
            sel_idx = best_idx_reg;
        end
    end

    always_comb
    begin
        stat.full     = (count_reg == CNT_W'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.pos_zero = (pos_reg == '0);
        stat.lc_in    = (lc_ext < count_ext);
        stat.rc_in    = (rc_ext < count_ext);
        stat.up_beats = beats(cur_reg, rd_data_reg, mode);
        stat.dn_beats = beats(sel_key, cur_reg, mode);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_LAST:   rd_addr = last_idx;
            RD_PARENT: rd_addr = parent_idx;
            RD_LC:     rd_addr = ADDR_W'(lc_ext);
            RD_RC:     rd_addr = ADDR_W'(rc_ext);
            default:   rd_addr = '0;
        endcase
    end

    assign wr_en   = cmd.wr_cur | cmd.up_move | cmd.dn_move;
    assign wr_data = cmd.wr_cur ? cur_reg : (cmd.up_move ? rd_data_reg : sel_key);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[pos_reg] <= wr_data;
        if (cmd.mem_rd)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        cur_next      = cur_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        has_rc_next   = has_rc_reg;
        root_next     = root_reg;
        count_next    = count_reg;
        if (cmd.init_ins)
        begin
            // The count already includes the new key; the walk never reads it.
            cur_next   = key_value;
            pos_next   = ADDR_W'(count_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.cap_root)
            root_next = rd_data_reg;
        if (cmd.cap_last)
        begin
            cur_next   = rd_data_reg;
            pos_next   = '0;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.cap_lc)
        begin
            best_next     = rd_data_reg;
            best_idx_next = ADDR_W'(lc_ext);
            has_rc_next   = stat.rc_in;
        end
        if (cmd.up_move)
            pos_next = parent_idx;
        if (cmd.dn_move)
            pos_next = sel_idx;
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        has_rc_reg   <= has_rc_next;
        root_reg     <= root_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_count_reg <= 8'(count_reg);
            case (cmd.res_kind)
                RES_INS_OK:
                begin
                    out_root_reg   <= '0;
                    out_status_reg <= STAT_OK;
                end
                RES_FULL:
                begin
                    out_root_reg   <= '0;
                    out_status_reg <= STAT_FULL;
                end
                RES_EMPTY:
                begin
                    out_root_reg   <= mode ? SENTINEL_MIN_MODE : SENTINEL_MAX_MODE;
                    out_status_reg <= STAT_EMPTY;
                end
                RES_EXT_OK:
                begin
                    out_root_reg   <= root_reg;
                    out_status_reg <= STAT_OK;
                end
                default:
                begin
                    out_root_reg   <= '0;
                    out_status_reg <= STAT_OK;
                end
            endcase
        end
    end

    assign root_value  = out_root_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

endmodule

// File: design/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min or max binary-heap priority queue of signed 32-bit keys with an APB
// mode register.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one result transfer. The heap
// lives in a single-port store with a registered read, and that port sets the
// timing. An insert rises one level per step until it reaches the root or
// stops below it, and an extract sinks one level per step until it ends on a
// leaf or no child beats it; a full insert or an empty extract goes straight
// to its result. A finished result waits in the output register, and the
// next request is taken while it waits; the result after that holds the
// queue until the waiting one is taken. heap_mode (address 0, reset 1) keeps
// the smallest key at the root when 1 and the largest when 0; the user must
// write it only while the queue is idle, as the block itself does not enforce
// this, and stored keys are not reordered.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue
    import bhpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    req_type,
    input  logic signed [KEY_W-1:0] key_value,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic signed [KEY_W-1:0] root_value,
    output logic [1:0]              status,
    output logic [7:0]              entry_count
);

    logic       mode_reg;
    bhpq_cmd_t  cmd;
    bhpq_stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            mode_reg <= pwdata[0];
    end

    bhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bhpq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode_reg),
        .key_value   (key_value),
        .cmd         (cmd),
        .stat        (stat),
        .root_value  (root_value),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

// File: dv/tb_binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue
// Drives insert and extract requests through the valid/ready request channel,
// keeps a behavioral heap of its own to predict every response, and checks
// each response transfer in order. The ordering register is changed over APB
// between phases, including while keys are held.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue
    import bhpq_pkg::*;
;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    localparam logic MODE_MAX_ROOT = 1'b0;
    localparam logic MODE_MIN_ROOT = 1'b1;

    localparam logic [2:0] HEAP_MODE_ADDR = 3'd0;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // Wait past the longest extract, with a margin on top.
    localparam int DRAIN_CYCLES = 3 * ADDR_W + 40;

    typedef struct {
        logic signed [KEY_W-1:0] root;
        logic [1:0]              status;
        logic [7:0]              count;
    } heap_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    req_valid;
    logic                    req_ready;
    logic                    req_type;
    logic signed [KEY_W-1:0] key_value;
    logic                    rsp_valid;
    logic                    rsp_ready;
    logic signed [KEY_W-1:0] root_value;
    logic [1:0]              status;
    logic [7:0]              entry_count;

    // Behavioral heap used to predict the responses.
    logic signed [KEY_W-1:0] model_keys [CAPACITY];
    int                      model_len;
    logic                    model_min_first;

    heap_result_t predicted_results [$];
    int           mismatch_count;
    int           results_seen;
    bit           no_idle;
    int           rsp_hold_cycles;

    binary_heap_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .key_value   (key_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .root_value  (root_value),
        .status      (status),
        .entry_count (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic key_above(input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b);
        key_above = model_min_first ? (a < b) : (a > b);
    endfunction

    function automatic heap_result_t predict_heap_request(input logic op,
                                                          input logic signed [KEY_W-1:0] key);
        heap_result_t            res;
        int                      pos;
        int                      up;
        int                      best;
        int                      lc;
        int                      rc;
        logic signed [KEY_W-1:0] tmp;
        res.root   = '0;
        res.status = STAT_OK;
        if (op == REQ_INSERT)
        begin
            if (model_len >= CAPACITY)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                model_keys[model_len] = key;
                pos = model_len;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (!key_above(model_keys[pos], model_keys[up]))
                        break;
                    tmp = model_keys[pos];
                    model_keys[pos] = model_keys[up];
                    model_keys[up] = tmp;
                    pos = up;
                end
                model_len++;
            end
        end
        else if (model_len == 0)
        begin
            res.root   = model_min_first ? SENTINEL_MIN_MODE : SENTINEL_MAX_MODE;
            res.status = STAT_EMPTY;
        end
        else
        begin
            res.root = model_keys[0];
            model_keys[0] = model_keys[model_len - 1];
            model_len--;
            pos = 0;
            while (pos < model_len)
            begin
                best = pos;
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                // Strict comparisons: ties stay put and the left child wins.
                if (lc < model_len && key_above(model_keys[lc], model_keys[best]))
                    best = lc;
                if (rc < model_len && key_above(model_keys[rc], model_keys[best]))
                    best = rc;
                if (best == pos)
                    break;
                tmp = model_keys[pos];
                model_keys[pos] = model_keys[best];
                model_keys[best] = tmp;
                pos = best;
            end
        end
        res.count = 8'(model_len);
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = $urandom;
            5, 6, 7:       k = int'($urandom_range(0, 15)) - 8;
            8:             k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            default:       k = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
        endcase
        return k;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Returns at the clock edge at which the request transfer happens, with
    // valid still high so that a back-to-back request needs no extra edge.
    task automatic send_request(input logic op, input logic signed [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= op;
        key_value <= key;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted_results.push_back(predict_heap_request(op, key));
    endtask

    task automatic wait_until_drained();
        req_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the ordering register, then reads it back.
    task automatic set_heap_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEAP_MODE_ADDR;
        pwdata  <= {31'd0, mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model_min_first = mode;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'd0, mode})
            report_mismatch($sformatf("heap_mode read back %0h, expected %0h", prdata, mode));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_heap_result();
        heap_result_t want;
        results_seen++;
        if (predicted_results.size() == 0)
        begin
            report_mismatch($sformatf(
                "response %0d with no request pending: root %0d status %0d count %0d",
                results_seen, root_value, status, entry_count));
            return;
        end
        want = predicted_results.pop_front();
        if (root_value !== want.root || status !== want.status || entry_count !== want.count)
            report_mismatch($sformatf(
                "response %0d: root %0d/%0d status %0d/%0d count %0d/%0d (got/exp)",
                results_seen, root_value, want.root, status, want.status,
                entry_count, want.count));
    endtask

    task automatic test_directed_cases();
        // Reset leaves the queue in min mode: empty extract, extremes, ties.
        send_request(REQ_EXTRACT, 0);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_INSERT, KEY_MIN);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, -1);
        send_request(REQ_INSERT, 1);
        send_request(REQ_INSERT, KEY_MIN);
        repeat (7) send_request(REQ_EXTRACT, rand_key());
        wait_until_drained();
        set_heap_mode(MODE_MAX_ROOT);
        send_request(REQ_EXTRACT, KEY_MAX);
        send_request(REQ_INSERT, 9);
        send_request(REQ_INSERT, 7);
        send_request(REQ_INSERT, 7);
        send_request(REQ_INSERT, -3);
        send_request(REQ_EXTRACT, KEY_MIN);
        wait_until_drained();
        // The keys stay in max order; the following sift-downs use min order.
        set_heap_mode(MODE_MIN_ROOT);
        repeat (4) send_request(REQ_EXTRACT, rand_key());
    endtask

    task automatic test_fill_and_drain();
        wait_until_drained();
        set_heap_mode(MODE_MAX_ROOT);
        no_idle = 1'b1;
        repeat (CAPACITY + 3) send_request(REQ_INSERT, int'($urandom_range(0, 40)) - 20);
        no_idle = 1'b0;
        repeat (CAPACITY + 2) send_request(REQ_EXTRACT, rand_key());
    endtask

    task automatic test_output_backpressure();
        wait_until_drained();
        set_heap_mode(MODE_MIN_ROOT);
        no_idle = 1'b1;
        rsp_hold_cycles = 300;
        repeat (24)
            send_request(($urandom_range(0, 99) < 60) ? REQ_INSERT : REQ_EXTRACT, rand_key());
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned grow_pct [4] = '{70, 45, 30, 60};
        logic        phase_mode [4] = '{MODE_MAX_ROOT, MODE_MIN_ROOT, MODE_MAX_ROOT, MODE_MIN_ROOT};
        for (int p = 0; p < 4; p++)
        begin
            wait_until_drained();
            set_heap_mode(phase_mode[p]);
            no_idle = (p == 2);
            repeat (140)
                send_request(($urandom_range(0, 99) < grow_pct[p]) ? REQ_INSERT : REQ_EXTRACT,
                             rand_key());
        end
        no_idle = 1'b0;
    endtask

    // Response side: checks every transfer and stalls at random.
    initial
    begin
        int gap_left;
        gap_left = 0;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                check_heap_result();
            if (rsp_hold_cycles > 0)
            begin
                rsp_hold_cycles--;
                rsp_ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (rsp_valid && rsp_ready)
                    gap_left = pick_gap();
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = HEAP_MODE_ADDR;
        pwdata          = '0;
        req_valid       = 1'b0;
        req_type        = REQ_INSERT;
        key_value       = '0;
        model_len       = 0;
        model_min_first = MODE_MIN_ROOT;
        mismatch_count  = 0;
        results_seen    = 0;
        no_idle         = 1'b0;
        rsp_hold_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_fill_and_drain();
        test_output_backpressure();
        test_random_traffic();
        wait_until_drained();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
design/bhpq_pkg.sv
design/bhpq_ctrl.sv
design/bhpq_dpath.sv
design/binary_heap_priority_queue.sv
dv/tb_binary_heap_priority_queue.sv
